>>> src/tlc_pkg.sv
package tlc_pkg;

  localparam int unsigned ADDR_BITS   = 48;
  localparam int unsigned OFF_BITS    = 6;
  localparam int unsigned WAYS        = 8;
  localparam int unsigned WAY_BITS    = 3;
  localparam int unsigned L1_SETS     = 64;
  localparam int unsigned L2_SETS     = 512;
  localparam int unsigned L1_SET_BITS = 6;
  localparam int unsigned L2_SET_BITS = 9;
  localparam int unsigned LINE_BITS   = ADDR_BITS - OFF_BITS;
  localparam int unsigned T1_BITS     = LINE_BITS - L1_SET_BITS;
  localparam int unsigned T2_BITS     = LINE_BITS - L2_SET_BITS;
  localparam int unsigned SET_GAP     = L2_SET_BITS - L1_SET_BITS;
  localparam int unsigned CNT_BITS    = 40;
  localparam int unsigned ORD_BITS    = WAYS * WAYS;

  localparam logic [ORD_BITS-1:0] ORDER_INIT = 64'h7F3F1F0F07030100;

  typedef struct packed {
    logic [WAYS-1:0][T1_BITS-1:0] tags;
    logic [WAYS-1:0]              valid;
    logic [WAYS-1:0]              dirty;
    logic [ORD_BITS-1:0]          order;
  } l1_set_t;

  typedef struct packed {
    logic [WAYS-1:0][T2_BITS-1:0] tags;
    logic [WAYS-1:0]              valid;
    logic [WAYS-1:0]              dirty;
    logic [ORD_BITS-1:0]          order;
  } l2_set_t;

  typedef struct packed {
    logic [CNT_BITS-1:0] reads;
    logic [CNT_BITS-1:0] writes;
    logic [CNT_BITS-1:0] l1_hits;
    logic [CNT_BITS-1:0] first_misses;
    logic [CNT_BITS-1:0] l2_hits;
    logic [CNT_BITS-1:0] second_misses;
    logic [CNT_BITS-1:0] wbs;
  } cnt_t;

  typedef struct packed {
    logic       en;
    logic       first;
    logic       write_op;
    logic       l1_hit;
    logic       l2_hit;
    logic [1:0] wb;
  } stats_upd_t;

  // Lowest set bit; the top bit of the result says whether any bit was set.
  function automatic logic [WAY_BITS:0] lowest(logic [WAYS-1:0] v);
    logic [WAY_BITS:0] r;
    r = '0;
    for (int i = WAYS - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = {1'b1, WAY_BITS'(i)};
      end
    end
    return r;
  endfunction

  // Row of the touched way becomes all ones, then its column is cleared.
  function automatic logic [ORD_BITS-1:0] order_touch(logic [ORD_BITS-1:0] m,
                                                      logic [WAY_BITS-1:0] w);
    logic [ORD_BITS-1:0] r;
    r = m;
    for (int j = 0; j < WAYS; j++) begin
      r[{w, WAY_BITS'(j)}] = 1'b1;
    end
    for (int i = 0; i < WAYS; i++) begin
      r[{WAY_BITS'(i), w}] = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [WAY_BITS-1:0] pick_victim(logic [ORD_BITS-1:0] m,
                                                      logic [WAYS-1:0] valid);
    logic [WAYS-1:0]   empty_row;
    logic [WAY_BITS:0] r;
    for (int i = 0; i < WAYS; i++) begin
      empty_row[i] = (m[i*WAYS +: WAYS] == '0);
    end
    if (valid != '1) begin
      r = lowest(~valid);
    end else begin
      r = lowest(empty_row);
    end
    return r[WAY_BITS-1:0];
  endfunction

  function automatic logic [WAY_BITS:0] l2_probe(l2_set_t row, logic [T2_BITS-1:0] tag);
    logic [WAYS-1:0] hv;
    for (int i = 0; i < WAYS; i++) begin
      hv[i] = row.valid[i] && (row.tags[i] == tag);
    end
    return lowest(hv);
  endfunction

  function automatic logic l2_alloc_wb(l2_set_t row);
    logic [WAY_BITS-1:0] v;
    v = pick_victim(row.order, row.valid);
    return row.valid[v] & row.dirty[v];
  endfunction

  function automatic l2_set_t l2_alloc(l2_set_t row, logic [T2_BITS-1:0] tag, logic dirty);
    logic [WAY_BITS-1:0] v;
    l2_set_t             r;
    v = pick_victim(row.order, row.valid);
    r = row;
    r.tags[v]  = tag;
    r.valid[v] = 1'b1;
    r.dirty[v] = dirty;
    r.order    = order_touch(row.order, v);
    return r;
  endfunction

endpackage

>>> src/tlc_in_if.sv
interface tlc_in_if;
  logic                          valid;
  logic                          ready;
  logic [tlc_pkg::ADDR_BITS-1:0] address;
  logic                          write_op;
  logic                          first_of_run;

  modport source (output valid, address, write_op, first_of_run, input ready);
  modport sink   (input valid, address, write_op, first_of_run, output ready);
endinterface

>>> src/tlc_out_if.sv
interface tlc_out_if;
  logic                         valid;
  logic                         ready;
  logic                         l1_hit;
  logic                         l2_hit;
  logic [1:0]                   memory_writebacks;
  logic [tlc_pkg::CNT_BITS-1:0] reads_total;
  logic [tlc_pkg::CNT_BITS-1:0] writes_total;
  logic [tlc_pkg::CNT_BITS-1:0] l1_hits_total;
  logic [tlc_pkg::CNT_BITS-1:0] l1_misses_total;
  logic [tlc_pkg::CNT_BITS-1:0] l2_hits_total;
  logic [tlc_pkg::CNT_BITS-1:0] l2_misses_total;
  logic [tlc_pkg::CNT_BITS-1:0] writebacks_total;

  modport source (output valid, l1_hit, l2_hit, memory_writebacks, reads_total, writes_total,
                  l1_hits_total, l1_misses_total, l2_hits_total, l2_misses_total,
                  writebacks_total, input ready);
  modport sink   (input valid, l1_hit, l2_hit, memory_writebacks, reads_total, writes_total,
                  l1_hits_total, l1_misses_total, l2_hits_total, l2_misses_total,
                  writebacks_total, output ready);
endinterface

>>> src/tlc_set_ram.sv
module tlc_set_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> src/tlc_stats.sv
module tlc_stats (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlc_pkg::stats_upd_t upd_i,
  output tlc_pkg::cnt_t       cnt_o
);
  import tlc_pkg::*;

  cnt_t cnt_q, cnt_d, base;

  always_comb begin
    base  = upd_i.first ? '0 : cnt_q;
    cnt_d = cnt_q;
    if (upd_i.en) begin
      cnt_d.reads         = base.reads + CNT_BITS'(!upd_i.write_op);
      cnt_d.writes        = base.writes + CNT_BITS'(upd_i.write_op);
      cnt_d.l1_hits       = base.l1_hits + CNT_BITS'(upd_i.l1_hit);
      cnt_d.first_misses  = base.first_misses + CNT_BITS'(!upd_i.l1_hit);
      cnt_d.l2_hits       = base.l2_hits + CNT_BITS'(upd_i.l2_hit);
      cnt_d.second_misses = base.second_misses + CNT_BITS'(!upd_i.l1_hit && !upd_i.l2_hit);
      cnt_d.wbs           = base.wbs + CNT_BITS'(upd_i.wb);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

>>> src/two_level_cache_lru_stats.sv
// Each accepted beat passes through PROBE and DONE, or through PROBE, VREAD, VMOD and DONE
// when a dirty L1 victim goes to L2, which adds a read and a write of its L2 set. A new beat
// is taken only in IDLE, after the previous result has entered the output register. The set
// memories each have one read and one write port and every access is a read-modify-write.
// Reset: asynchronous and active low. After reset a clearing pass walks all 512 L2 sets, and
// the 64 L1 sets alongside the first of them, before the first beat is taken.
module two_level_cache_lru_stats (
  input  logic      clk_i,
  input  logic      rst_ni,
  tlc_in_if.sink    in_i,
  tlc_out_if.source out_o
);
  import tlc_pkg::*;

  // One-hot sequencer. PROBE sees both set rows; VREAD/VMOD handle a dirty L1 victim.
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_PROBE = 6'b000100,
    S_VREAD = 6'b001000,
    S_VMOD  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [L2_SET_BITS-1:0] clr_q;

  // Request fields held for the whole access.
  logic [L1_SET_BITS-1:0] s1_q;
  logic [T1_BITS-1:0]     t1_q;
  logic [L2_SET_BITS-1:0] s2_q;
  logic [T2_BITS-1:0]     t2_q;
  logic                   wr_q, first_q;
  logic [T1_BITS-1:0]     vtag_q;

  // Per-access result, and the output register that holds it for the sink.
  logic       hit1_q, hit2_q;
  logic [1:0] wb_q;
  logic       out_valid_q, out_l1_q, out_l2_q;
  logic [1:0] out_wb_q;

  logic [LINE_BITS-1:0] line;
  logic                 accept, done_fire;

  l1_set_t l1_rd, l1_new, l1_wdata;
  l2_set_t l2_rd, l2_new, l2_vnew, l2_wdata;
  logic    l1_we, l2_we, l2_re;
  logic [L1_SET_BITS-1:0] l1_waddr;
  logic [L2_SET_BITS-1:0] l2_waddr, l2_raddr, sv;
  logic [T2_BITS-1:0]     tv;

  logic [WAYS-1:0]     h1_vec;
  logic [WAY_BITS:0]   h1, h2, hv;
  logic [WAY_BITS-1:0] v1;
  logic                vdirty, l2_wb, v_wb;

  stats_upd_t upd;
  cnt_t       cnt;

  assign line   = in_i.address[ADDR_BITS-1:OFF_BITS];
  assign accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);

  // The dirty victim's line maps into L2 by appending the L1 set below its tag.
  assign sv = {vtag_q[SET_GAP-1:0], s1_q};
  assign tv = vtag_q[T1_BITS-1:SET_GAP];

  // Result of the probe stage: L1 lookup, L2 lookup or allocation, L1 refill.
  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      h1_vec[i] = l1_rd.valid[i] && (l1_rd.tags[i] == t1_q);
    end
    h1     = lowest(h1_vec);
    h2     = l2_probe(l2_rd, t2_q);
    v1     = pick_victim(l1_rd.order, l1_rd.valid);
    vdirty = l1_rd.valid[v1] & l1_rd.dirty[v1];
    l1_new = l1_rd;
    l2_new = l2_rd;
    l2_wb  = 1'b0;
    if (h1[WAY_BITS]) begin
      l1_new.order = order_touch(l1_rd.order, h1[WAY_BITS-1:0]);
      if (wr_q) begin
        l1_new.dirty[h1[WAY_BITS-1:0]] = 1'b1;
      end
    end else begin
      if (h2[WAY_BITS]) begin
        l2_new.order = order_touch(l2_rd.order, h2[WAY_BITS-1:0]);
      end else begin
        l2_new = l2_alloc(l2_rd, t2_q, 1'b0);
        l2_wb  = l2_alloc_wb(l2_rd);
      end
      l1_new.tags[v1]  = t1_q;
      l1_new.valid[v1] = 1'b1;
      l1_new.dirty[v1] = wr_q;
      l1_new.order     = order_touch(l1_rd.order, v1);
    end
  end

  // Dirty victim: mark the L2 copy dirty without touching its order, or allocate it dirty.
  always_comb begin
    hv      = l2_probe(l2_rd, tv);
    l2_vnew = l2_rd;
    v_wb    = 1'b0;
    if (hv[WAY_BITS]) begin
      l2_vnew.dirty[hv[WAY_BITS-1:0]] = 1'b1;
    end else begin
      l2_vnew = l2_alloc(l2_rd, tv, 1'b1);
      v_wb    = l2_alloc_wb(l2_rd);
    end
  end

  // Memory port steering. During the clearing pass both memories take the reset row.
  always_comb begin
    l1_we    = 1'b0;
    l1_waddr = s1_q;
    l1_wdata = l1_new;
    l2_we    = 1'b0;
    l2_waddr = s2_q;
    l2_wdata = l2_new;
    l2_re    = accept;
    l2_raddr = line[L2_SET_BITS-1:0];
    case (state_q)
      S_CLEAR: begin
        l1_we          = (clr_q < L2_SET_BITS'(L1_SETS));
        l1_waddr       = clr_q[L1_SET_BITS-1:0];
        l1_wdata       = '0;
        l1_wdata.order = ORDER_INIT;
        l2_we          = 1'b1;
        l2_waddr       = clr_q;
        l2_wdata       = '0;
        l2_wdata.order = ORDER_INIT;
      end
      S_PROBE: begin
        l1_we = 1'b1;
        l2_we = !h1[WAY_BITS];
      end
      S_VREAD: begin
        // The L2 write of the probe stage has landed, so a read of the same set is current.
        l2_re    = 1'b1;
        l2_raddr = sv;
      end
      S_VMOD: begin
        l2_we    = 1'b1;
        l2_waddr = sv;
        l2_wdata = l2_vnew;
      end
      default: begin
      end
    endcase
  end

  assign done_fire = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: if (clr_q == L2_SET_BITS'(L2_SETS - 1)) state_d = S_IDLE;
      S_IDLE:  if (accept) state_d = S_PROBE;
      S_PROBE: begin
        if (!h1[WAY_BITS] && vdirty) begin
          state_d = S_VREAD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_VREAD: state_d = S_VMOD;
      S_VMOD:  state_d = S_DONE;
      S_DONE:  if (done_fire) state_d = S_IDLE;
      default: state_d = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + L2_SET_BITS'(1);
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q    <= line[L1_SET_BITS-1:0];
      t1_q    <= line[LINE_BITS-1:L1_SET_BITS];
      s2_q    <= line[L2_SET_BITS-1:0];
      t2_q    <= line[LINE_BITS-1:L2_SET_BITS];
      wr_q    <= in_i.write_op;
      first_q <= in_i.first_of_run;
    end
    if (state_q == S_PROBE) begin
      hit1_q <= h1[WAY_BITS];
      hit2_q <= !h1[WAY_BITS] && h2[WAY_BITS];
      wb_q   <= {1'b0, !h1[WAY_BITS] && l2_wb};
      vtag_q <= l1_rd.tags[v1];
    end
    if (state_q == S_VMOD) begin
      wb_q <= wb_q + {1'b0, v_wb};
    end
    if (done_fire) begin
      out_l1_q <= hit1_q;
      out_l2_q <= hit2_q;
      out_wb_q <= wb_q;
    end
  end

  tlc_set_ram #(
    .DEPTH (L1_SETS),
    .WIDTH ($bits(l1_set_t))
  ) u_l1_ram (
    .clk_i   (clk_i),
    .we_i    (l1_we),
    .waddr_i (l1_waddr),
    .wdata_i (l1_wdata),
    .re_i    (accept),
    .raddr_i (line[L1_SET_BITS-1:0]),
    .rdata_o (l1_rd)
  );

  tlc_set_ram #(
    .DEPTH (L2_SETS),
    .WIDTH ($bits(l2_set_t))
  ) u_l2_ram (
    .clk_i   (clk_i),
    .we_i    (l2_we),
    .waddr_i (l2_waddr),
    .wdata_i (l2_wdata),
    .re_i    (l2_re),
    .raddr_i (l2_raddr),
    .rdata_o (l2_rd)
  );

  // Counters advance as the result enters the output register, so they match that beat.
  assign upd.en       = done_fire;
  assign upd.first    = first_q;
  assign upd.write_op = wr_q;
  assign upd.l1_hit   = hit1_q;
  assign upd.l2_hit   = hit2_q;
  assign upd.wb       = wb_q;

  tlc_stats u_stats (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  (upd),
    .cnt_o  (cnt)
  );

  assign out_o.valid             = out_valid_q;
  assign out_o.l1_hit            = out_l1_q;
  assign out_o.l2_hit            = out_l2_q;
  assign out_o.memory_writebacks = out_wb_q;
  assign out_o.reads_total       = cnt.reads;
  assign out_o.writes_total      = cnt.writes;
  assign out_o.l1_hits_total     = cnt.l1_hits;
  assign out_o.l1_misses_total   = cnt.first_misses;
  assign out_o.l2_hits_total     = cnt.l2_hits;
  assign out_o.l2_misses_total   = cnt.second_misses;
  assign out_o.writebacks_total  = cnt.wbs;

endmodule

>>> bench/two_level_cache_lru_stats_check.sv
`timescale 1ns / 1ps
module two_level_cache_lru_stats_check (
  input  logic      clk_i,
  input  logic      rst_ni,
  tlc_in_if.sink    in_i,
  tlc_out_if.sink   out_i,
  output int        errors_o,
  output int        pending_o,
  output logic      beat_o
);
  import tlc_pkg::*;

  typedef struct {
    logic                l1_hit;
    logic                l2_hit;
    logic [1:0]          wbs;
    logic [CNT_BITS-1:0] tot [7];
  } outcome_t;

  logic [T1_BITS-1:0]  l1_tag   [L1_SETS][WAYS];
  logic [WAYS-1:0]     l1_vld   [L1_SETS];
  logic [WAYS-1:0]     l1_dty   [L1_SETS];
  logic [ORD_BITS-1:0] l1_ord   [L1_SETS];
  logic [T2_BITS-1:0]  l2_tag   [L2_SETS][WAYS];
  logic [WAYS-1:0]     l2_vld   [L2_SETS];
  logic [WAYS-1:0]     l2_dty   [L2_SETS];
  logic [ORD_BITS-1:0] l2_ord   [L2_SETS];
  logic [CNT_BITS-1:0] stats    [7];
  outcome_t            awaited  [$];

  function automatic logic [ORD_BITS-1:0] touch(logic [ORD_BITS-1:0] m, int w);
    for (int j = 0; j < WAYS; j++) m[w*WAYS+j] = 1'b1;
    for (int i = 0; i < WAYS; i++) m[i*WAYS+w] = 1'b0;
    return m;
  endfunction

  function automatic int victim(logic [ORD_BITS-1:0] m, logic [WAYS-1:0] v);
    for (int w = 0; w < WAYS; w++) if (!v[w]) return w;
    for (int w = 0; w < WAYS; w++) if (m[w*WAYS +: WAYS] == '0) return w;
    return 0;
  endfunction

  function automatic int l2_find(int s, logic [T2_BITS-1:0] t);
    for (int w = 0; w < WAYS; w++) if (l2_vld[s][w] && l2_tag[s][w] == t) return w;
    return -1;
  endfunction

  // Places a line in the second level; reports whether a dirty line went to memory.
  function automatic int l2_place(int s, logic [T2_BITS-1:0] t, logic d);
    int v;
    int wb;
    v = victim(l2_ord[s], l2_vld[s]);
    wb = int'(l2_vld[s][v] & l2_dty[s][v]);
    l2_tag[s][v] = t;
    l2_vld[s][v] = 1'b1;
    l2_dty[s][v] = d;
    l2_ord[s] = touch(l2_ord[s], v);
    return wb;
  endfunction

  function automatic outcome_t cache_access(logic [ADDR_BITS-1:0] a, logic wr, logic clr);
    outcome_t           o;
    logic [LINE_BITS-1:0] ln, vln;
    int s1, s2, w, v, wb, sv;
    ln = a[ADDR_BITS-1:OFF_BITS];
    s1 = int'(ln[L1_SET_BITS-1:0]);
    s2 = int'(ln[L2_SET_BITS-1:0]);
    wb = 0;
    o.l1_hit = 1'b0;
    o.l2_hit = 1'b0;
    if (clr) for (int k = 0; k < 7; k++) stats[k] = '0;
    stats[wr ? 1 : 0]++;
    w = -1;
    for (int i = 0; i < WAYS; i++)
      if (w < 0 && l1_vld[s1][i] && l1_tag[s1][i] == ln[LINE_BITS-1:L1_SET_BITS]) w = i;
    if (w >= 0) begin
      o.l1_hit = 1'b1;
      stats[2]++;
      l1_ord[s1] = touch(l1_ord[s1], w);
      if (wr) l1_dty[s1][w] = 1'b1;
    end else begin
      stats[3]++;
      w = l2_find(s2, ln[LINE_BITS-1:L2_SET_BITS]);
      if (w >= 0) begin
        o.l2_hit = 1'b1;
        stats[4]++;
        l2_ord[s2] = touch(l2_ord[s2], w);
      end else begin
        stats[5]++;
        wb += l2_place(s2, ln[LINE_BITS-1:L2_SET_BITS], 1'b0);
      end
      v = victim(l1_ord[s1], l1_vld[s1]);
      if (l1_vld[s1][v] && l1_dty[s1][v]) begin
        // The dirty line leaving the first level is written back into the second.
        vln = {l1_tag[s1][v], L1_SET_BITS'(s1)};
        sv = int'(vln[L2_SET_BITS-1:0]);
        w = l2_find(sv, vln[LINE_BITS-1:L2_SET_BITS]);
        if (w >= 0) l2_dty[sv][w] = 1'b1;
        else wb += l2_place(sv, vln[LINE_BITS-1:L2_SET_BITS], 1'b1);
      end
      l1_tag[s1][v] = ln[LINE_BITS-1:L1_SET_BITS];
      l1_vld[s1][v] = 1'b1;
      l1_dty[s1][v] = wr;
      l1_ord[s1] = touch(l1_ord[s1], v);
    end
    stats[6] += CNT_BITS'(wb);
    o.wbs = 2'(wb);
    for (int k = 0; k < 7; k++) o.tot[k] = stats[k];
    return o;
  endfunction

  assign pending_o = awaited.size();
  assign beat_o = (in_i.valid && in_i.ready) || (out_i.valid && out_i.ready);

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t e;
    logic [CNT_BITS-1:0] got [7];
    if (!rst_ni) begin
      errors_o <= 0;
      awaited.delete();
      for (int s = 0; s < L1_SETS; s++) begin
        l1_vld[s] = '0; l1_dty[s] = '0; l1_ord[s] = ORDER_INIT;
        for (int w = 0; w < WAYS; w++) l1_tag[s][w] = '0;
      end
      for (int s = 0; s < L2_SETS; s++) begin
        l2_vld[s] = '0; l2_dty[s] = '0; l2_ord[s] = ORDER_INIT;
        for (int w = 0; w < WAYS; w++) l2_tag[s][w] = '0;
      end
      for (int k = 0; k < 7; k++) stats[k] = '0;
    end else begin
      if (in_i.valid && in_i.ready)
        awaited.push_back(cache_access(in_i.address, in_i.write_op, in_i.first_of_run));
      if (out_i.valid && out_i.ready) begin
        got = '{out_i.reads_total, out_i.writes_total, out_i.l1_hits_total,
                out_i.l1_misses_total, out_i.l2_hits_total, out_i.l2_misses_total,
                out_i.writebacks_total};
        if (awaited.size() == 0) begin
          $display("%0t: result beat with nothing expected", $time);
          errors_o <= errors_o + 1;
        end else begin
          e = awaited.pop_front();
          if (e.l1_hit !== out_i.l1_hit || e.l2_hit !== out_i.l2_hit ||
              e.wbs !== out_i.memory_writebacks || e.tot != got) begin
            $display("%0t: expected hit %b/%b wb %0d totals %p, got hit %b/%b wb %0d totals %p",
                     $time, e.l1_hit, e.l2_hit, e.wbs, e.tot, out_i.l1_hit, out_i.l2_hit,
                     out_i.memory_writebacks, got);
            errors_o <= errors_o + 1;
          end
        end
      end
    end
  end
endmodule

>>> bench/two_level_cache_lru_stats_test.sv
`timescale 1ns / 1ps
module two_level_cache_lru_stats_test;
  import tlc_pkg::*;

  localparam int DOG_LIMIT = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   errors, pending, idle_cycles;
  logic beat;
  int   send_idle, recv_idle;   // per-hundred odds of a gap on each side
  bit   hold_off = 0;           // long receiver stall, set during one phase
  bit   finished = 0;

  tlc_in_if  in_ch ();
  tlc_out_if out_ch ();

  two_level_cache_lru_stats dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_o(out_ch));

  two_level_cache_lru_stats_check checker_u (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch), .out_i(out_ch),
    .errors_o(errors), .pending_o(pending), .beat_o(beat)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // A small pool of line addresses keeps most accesses inside a few sets, so that
  // hits, evictions and dirty write-backs all happen often. Lines that share an L1
  // set but differ in L2 set and tag put pressure on both levels.
  logic [ADDR_BITS-1:0] pool [48];

  // The receiver takes each result beat unless it is stalling at random or is held off.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ch.ready <= 1'b0;
    else out_ch.ready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  // Offers one beat and holds it until accepted; gaps fall between beats at random.
  // It returns at the falling edge after the accept, with valid still high, so the
  // next beat or gap takes over in that same step.
  task automatic offer(logic [ADDR_BITS-1:0] a, logic wr, logic clr);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.address <= a;
    in_ch.write_op <= wr;
    in_ch.first_of_run <= clr;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic random_access();
    logic [ADDR_BITS-1:0] a;
    int pick;
    pick = $urandom_range(99);
    if (pick < 85) a = pool[$urandom_range(47)] | ADDR_BITS'($urandom_range(63));
    else a = ADDR_BITS'({$urandom, $urandom});
    offer(a, 1'($urandom_range(1)), $urandom_range(99) < 3);
  endtask

  // The watchdog counts cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if (beat || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > DOG_LIMIT && !finished) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int lim[4] = '{0, 71, 0, 19};
    int rlim[4] = '{0, 0, 71, 19};
    logic [ADDR_BITS-1:0] high_all;
    in_ch.valid = 1'b0;
    in_ch.address = '0;
    in_ch.write_op = 1'b0;
    in_ch.first_of_run = 1'b0;
    send_idle = 0;
    recv_idle = 0;
    for (int i = 0; i < 48; i++)
      pool[i] = {ADDR_BITS'($urandom_range(3)) << 20 | ADDR_BITS'($urandom_range(7)) << 15
                 | ADDR_BITS'($urandom_range(1)) << 12} | (ADDR_BITS'(i % 2) << 6);
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: extreme addresses, a fresh run, and one L1 set overfilled with
    // dirty lines so that dirty victims land in L2 and then leave it for memory.
    high_all = '1;
    offer('0, 1'b0, 1'b1);
    offer(high_all, 1'b1, 1'b0);
    offer(high_all, 1'b0, 1'b0);
    offer('0, 1'b1, 1'b0);
    for (int i = 0; i < 19; i++)
      offer(ADDR_BITS'(i) << 15, 1'b1, 1'b0);
    offer('0, 1'b0, 1'b1);

    // Random part in four idling phases; the second phase starts with a long hold-off
    // while the sender keeps offering, so the block fills and stalls its input.
    for (int p = 0; p < 4; p++) begin
      send_idle = lim[p];
      recv_idle = rlim[p];
      if (p == 1) begin
        hold_off = 1;
        fork
          begin
            repeat (300) @(negedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      for (int n = 0; n < 380; n++) random_access();
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    finished = 1;
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
